[rtl/core/rsg_pkg.sv]
`timescale 1ns / 1ps
package rsg_pkg;

  localparam int unsigned MaxParity = 14;
  localparam int unsigned SymW      = 4;
  localparam int unsigned CntW      = 4;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [CntW-1:0] ParityReset = 4'd4;
  localparam logic [4:0]      PolyReset   = 5'd19;
  localparam logic [CntW-1:0] ParityMin   = 4'd2;

  localparam logic REG_PARITY = 1'b0;
  localparam logic REG_POLY   = 1'b1;

  typedef logic [SymW-1:0] sym_t;
  typedef logic [MaxParity-1:0][SymW-1:0] sym_vec_t;

  typedef struct packed {
    logic load;
    logic last;
  } msg_ctrl_t;

  function automatic sym_t gf_mul(sym_t a, sym_t b, logic [3:0] low);
    sym_t acc;
    logic top;
    acc = '0;
    for (int bit_idx = 3; bit_idx >= 0; bit_idx--) begin
      top = acc[3];
      acc = {acc[2:0], 1'b0};
      if (top) begin
        acc = acc ^ low;
      end
      if (b[bit_idx]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

endpackage

[rtl/core/rsg_gen.sv]
`timescale 1ns / 1ps
module rsg_gen import rsg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CntW-1:0] parity_count_i,
  input  logic [3:0]      poly_low_i,
  output sym_vec_t        gen_o,
  output logic            busy_o
);

  sym_vec_t        full_q, full_d;
  sym_t            root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;

  always_comb begin
    full_d = full_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      full_d    = '0;
      full_d[0] = 4'd1;
      root_d    = 4'd1;
      cnt_d     = 4'd1;
      busy_d    = 1'b1;
    end else if (busy_q) begin
      root_d    = gf_mul(root_q, 4'd2, poly_low_i);
      full_d[0] = gf_mul(root_d, full_q[0], poly_low_i);
      for (int j = 1; j < MaxParity; j++) begin
        full_d[j] = full_q[j-1] ^ gf_mul(root_d, full_q[j], poly_low_i);
      end
      cnt_d  = cnt_q + 4'd1;
      busy_d = (cnt_q != parity_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= {{((MaxParity-1)*SymW){1'b0}}, 4'd1};
      root_q <= 4'd1;
      cnt_q  <= 4'd1;
      busy_q <= 1'b1;
    end else begin
      full_q <= full_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign gen_o  = full_q;
  assign busy_o = busy_q;

endmodule

[rtl/core/rsg_lfsr.sv]
`timescale 1ns / 1ps
module rsg_lfsr import rsg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  msg_ctrl_t       ctrl_i,
  input  logic            clear_i,
  input  sym_t            message_symbol_i,
  input  logic [CntW-1:0] parity_count_i,
  input  logic [3:0]      poly_low_i,
  input  sym_vec_t        gen_i,
  output sym_vec_t        rem_next_o
);

  sym_vec_t        rem_q, rem_d, rem_next;
  sym_t            fb;
  logic [CntW-1:0] top_idx;

  assign top_idx = parity_count_i - 4'd1;
  assign fb      = message_symbol_i ^ rem_q[top_idx];

  always_comb begin
    rem_next[0] = gf_mul(fb, gen_i[0], poly_low_i);
    for (int j = 1; j < MaxParity; j++) begin
      rem_next[j] = rem_q[j-1] ^ gf_mul(fb, gen_i[j], poly_low_i);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (clear_i) begin
      rem_d = '0;
    end else if (ctrl_i.load) begin
      rem_d = ctrl_i.last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rem_next_o = rem_next;

endmodule

[rtl/core/rsg_out.sv]
`timescale 1ns / 1ps
module rsg_out import rsg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  msg_ctrl_t       ctrl_i,
  input  sym_t            message_symbol_i,
  input  sym_vec_t        rem_next_i,
  input  logic [CntW-1:0] parity_count_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output sym_t            code_symbol_o,
  output logic            is_parity_o,
  output logic            end_of_codeword_o,
  output logic            draining_o,
  output logic            can_load_o
);

  sym_vec_t        par_q, par_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] top_idx;
  logic            valid_q, valid_d;
  sym_t            sym_q, sym_d;
  logic            par_flag_q, par_flag_d;
  logic            end_q, end_d;
  logic            can_load;

  assign can_load = !valid_q || out_ready_i;
  assign top_idx  = parity_count_i - 4'd1;

  always_comb begin
    par_d      = par_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    sym_d      = sym_q;
    par_flag_d = par_flag_q;
    end_d      = end_q;
    if (can_load) begin
      if (cnt_q != '0) begin
        valid_d    = 1'b1;
        sym_d      = par_q[top_idx];
        par_flag_d = 1'b1;
        end_d      = (cnt_q == 4'd1);
        par_d      = {par_q[MaxParity-2:0], 4'd0};
        cnt_d      = cnt_q - 4'd1;
      end else if (ctrl_i.load) begin
        valid_d    = 1'b1;
        sym_d      = message_symbol_i;
        par_flag_d = 1'b0;
        end_d      = 1'b0;
        if (ctrl_i.last) begin
          par_d = rem_next_i;
          cnt_d = parity_count_i;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    par_q      <= par_d;
    sym_q      <= sym_d;
    par_flag_q <= par_flag_d;
    end_q      <= end_d;
  end

  assign out_valid_o       = valid_q;
  assign code_symbol_o     = sym_q;
  assign is_parity_o       = par_flag_q;
  assign end_of_codeword_o = end_q;
  assign draining_o        = (cnt_q != '0);
  assign can_load_o        = can_load;

endmodule

[rtl/core/reed_solomon_gf16_encoder_top.sv]
// An accepted message symbol appears at the output in the next cycle.
// Throughput: one message symbol per cycle unless the output stalls or a rebuild runs;
// a last symbol is followed by parity_count parity symbols from the output register,
// during which in_ready_o is low. Reset clears the remainder and rebuilds the generator
// for parity_count 4 over x^4+x+1; any register write rebuilds it, with in_ready_o low
// meanwhile.
`timescale 1ns / 1ps
module reed_solomon_gf16_encoder_top import rsg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       message_symbol_i,
  input  logic             last_symbol_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       code_symbol_o,
  output logic             is_parity_o,
  output logic             end_of_codeword_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [CntW-1:0] parity_q, parity_d;
  logic [4:0]      poly_q, poly_d;
  logic            cfg_wr;
  logic [CntW-1:0] wr_parity;
  sym_vec_t        gen;
  sym_vec_t        rem_next;
  logic            gen_busy;
  logic            draining;
  logic            can_load;
  msg_ctrl_t       ctrl;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign wr_parity = {pwdata[3:1], 1'b0};

  always_comb begin
    parity_d = parity_q;
    poly_d   = poly_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_PARITY: parity_d = (wr_parity < ParityMin) ? ParityMin : wr_parity;
        REG_POLY:   poly_d   = {1'b1, pwdata[3:0]};
        default:    parity_d = parity_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PARITY: prdata = {{(DataW-CntW){1'b0}}, parity_q};
      REG_POLY:   prdata = {{(DataW-5){1'b0}}, poly_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= ParityReset;
      poly_q   <= PolyReset;
    end else begin
      parity_q <= parity_d;
      poly_q   <= poly_d;
    end
  end

  assign in_ready_o = !gen_busy && !draining && can_load;
  assign ctrl.load  = in_valid_i && in_ready_o;
  assign ctrl.last  = last_symbol_i;

  rsg_gen u_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (cfg_wr),
    .parity_count_i (parity_q),
    .poly_low_i     (poly_q[3:0]),
    .gen_o          (gen),
    .busy_o         (gen_busy)
  );

  rsg_lfsr u_lfsr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .clear_i          (cfg_wr),
    .message_symbol_i (message_symbol_i),
    .parity_count_i   (parity_q),
    .poly_low_i       (poly_q[3:0]),
    .gen_i            (gen),
    .rem_next_o       (rem_next)
  );

  rsg_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .message_symbol_i  (message_symbol_i),
    .rem_next_i        (rem_next),
    .parity_count_i    (parity_q),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .code_symbol_o     (code_symbol_o),
    .is_parity_o       (is_parity_o),
    .end_of_codeword_o (end_of_codeword_o),
    .draining_o        (draining),
    .can_load_o        (can_load)
  );

endmodule

[rtl/core/rsg_chk.sv]
`timescale 1ns / 1ps
module rsg_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       last_symbol_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] code_symbol_o,
  input logic       is_parity_o,
  input logic       end_of_codeword_o,
  input logic       pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_symbol_o))
    else $error("stalled item changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_codeword_o |-> is_parity_o)
    else $error("end of codeword on a message item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_symbol_i |=> !in_ready_o)
    else $error("input taken while parity pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_symbol_i |=> out_valid_o && !is_parity_o)
    else $error("last message item missing at output");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind reed_solomon_gf16_encoder_top rsg_chk u_rsg_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .last_symbol_i     (last_symbol_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .code_symbol_o     (code_symbol_o),
  .is_parity_o       (is_parity_o),
  .end_of_codeword_o (end_of_codeword_o),
  .pready            (pready)
);
